>>> rtl/triangle_face_normal_assert.svh
// Assertion macros used by the checker of the triangle face normal block.
// Needs a clk and an active low arst_n in the scope where a macro is used.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tfn_pkg.sv
// Shared widths, types and helpers of the triangle face normal block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tfn_pkg;

	localparam int FIELD_W   = 16;
	localparam int POS_WIDTH = 16;
	localparam int EDGE_W    = POS_WIDTH + 1;
	localparam int PROD_W    = 2 * EDGE_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int MAG_W     = CROSS_W;
	localparam int BL_W      = $clog2(MAG_W + 1);
	localparam int NORM_BITS = 24;
	localparam int SH_W      = MAG_W + NORM_BITS;
	localparam int SHAMT_W   = $clog2(SH_W + 1);
	localparam int ROOT_W    = NORM_BITS + 1;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 1;
	localparam int Q_BITS    = 15;
	localparam int N_W       = NORM_BITS + Q_BITS + 1;
	localparam int D_W       = ROOT_W + 1;
	localparam int OUT_W     = 16;
	localparam int ONE_Q14   = 16384;
	localparam int QDEPTH    = 8;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int FRONT_STAGES = 5;
	// Edge of acceptance to the edge that takes the result.
	localparam int LATENCY   = FRONT_STAGES + 1 + 3 + ROOT_W + 1 + Q_BITS + 1;

	typedef logic [FIELD_W-1:0] idx_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [BL_W-1:0]       bl;
		logic                  degen;
		logic [2:0][FIELD_W-1:0] idx;
	} qent_t;

	typedef struct packed {
		logic [2:0][NORM_BITS-1:0] m;
		logic [2:0]                neg;
		logic                      degen;
		logic [2:0][FIELD_W-1:0]   idx;
	} side_t;

	// Low POS_WIDTH bits of a field, read as two's complement.
	function automatic logic signed [POS_WIDTH-1:0] pos_value(input logic [FIELD_W-1:0] raw);
		logic [FIELD_W+POS_WIDTH-1:0] t;
		t = {{POS_WIDTH{1'b0}}, raw};
		return t[POS_WIDTH-1:0];
	endfunction

endpackage

>>> rtl/tfn_front.sv
// Front part: edges, cross product, sign and magnitude, and leading-one search.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [2:0][tfn_pkg::FIELD_W-1:0]      v0,
	input  logic [2:0][tfn_pkg::FIELD_W-1:0]      v1,
	input  logic [2:0][tfn_pkg::FIELD_W-1:0]      v2,
	input  logic [2:0][tfn_pkg::FIELD_W-1:0]      idx,
	output logic                                  push,
	output tfn_pkg::qent_t                        push_data
);
	import tfn_pkg::*;

	function automatic logic [BL_W-1:0] bit_len(input logic [MAG_W-1:0] v);
		logic [BL_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) n = BL_W'(i + 1);
		end
		return n;
	endfunction

	logic signed [POS_WIDTH-1:0] a [3];
	logic signed [POS_WIDTH-1:0] b [3];
	logic signed [POS_WIDTH-1:0] c [3];

	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [EDGE_W-1:0]  e1_s1 [3];
	logic signed [EDGE_W-1:0]  e2_s1 [3];
	logic [2:0][FIELD_W-1:0]   idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [PROD_W-1:0]  p_s2 [6];
	logic [2:0][MAG_W-1:0]     mag_s3, mag_s4, mag_s5;
	logic [2:0]                neg_s3, neg_s4, neg_s5;
	logic [MAG_W-1:0]          big_s4;
	logic [BL_W-1:0]           bl_s5;
	logic                      degen_s5;

	logic signed [CROSS_W-1:0] cr [3];
	logic [MAG_W-1:0]          big01;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[k] = pos_value(v0[k]);
			b[k] = pos_value(v1[k]);
			c[k] = pos_value(v2[k]);
		end
	end

	always_comb begin
		cr[0] = $signed({p_s2[0][PROD_W-1], p_s2[0]}) - $signed({p_s2[1][PROD_W-1], p_s2[1]});
		cr[1] = $signed({p_s2[2][PROD_W-1], p_s2[2]}) - $signed({p_s2[3][PROD_W-1], p_s2[3]});
		cr[2] = $signed({p_s2[4][PROD_W-1], p_s2[4]}) - $signed({p_s2[5][PROD_W-1], p_s2[5]});
		big01 = (mag_s3[1] > mag_s3[0]) ? mag_s3[1] : mag_s3[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e1_s1[k] <= $signed({b[k][POS_WIDTH-1], b[k]}) - $signed({a[k][POS_WIDTH-1], a[k]});
			e2_s1[k] <= $signed({c[k][POS_WIDTH-1], c[k]}) - $signed({a[k][POS_WIDTH-1], a[k]});
		end
		idx_s1 <= idx;

		p_s2[0] <= e2_s1[1] * e1_s1[2];
		p_s2[1] <= e2_s1[2] * e1_s1[1];
		p_s2[2] <= e2_s1[2] * e1_s1[0];
		p_s2[3] <= e2_s1[0] * e1_s1[2];
		p_s2[4] <= e2_s1[0] * e1_s1[1];
		p_s2[5] <= e2_s1[1] * e1_s1[0];
		idx_s2  <= idx_s1;

		for (int k = 0; k < 3; k++) begin
			neg_s3[k] <= cr[k][CROSS_W-1];
			mag_s3[k] <= cr[k][CROSS_W-1] ? (~cr[k] + 1'b1) : cr[k];
		end
		idx_s3 <= idx_s2;

		big_s4 <= (mag_s3[2] > big01) ? mag_s3[2] : big01;
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		idx_s4 <= idx_s3;

		bl_s5    <= bit_len(big_s4);
		degen_s5 <= (big_s4 == '0);
		mag_s5   <= mag_s4;
		neg_s5   <= neg_s4;
		idx_s5   <= idx_s4;
	end

	assign push            = valid_s5;
	assign push_data.mag   = mag_s5;
	assign push_data.neg   = neg_s5;
	assign push_data.bl    = bl_s5;
	assign push_data.degen = degen_s5;
	assign push_data.idx   = idx_s5;

endmodule

>>> rtl/tfn_queue.sv
// Short queue of classified triangles between the front and back parts.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tfn_pkg::qent_t push_data,
	output logic           pop,
	output tfn_pkg::qent_t pop_data,
	output logic           full
);
	import tfn_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	// The back part never stalls, so an entry leaves as soon as it is there.
	assign pop      = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	// Leave room for the beats still inside the front pipeline.
	assign full     = (cnt_q >= (QPTR_W + 1)'(QDEPTH - FRONT_STAGES));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/tfn_back.sv
// Back part: scaling, sum of squares, pipelined square root and division.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  tfn_pkg::qent_t                        in_data,
	output logic                                  done,
	output logic signed [2:0][tfn_pkg::OUT_W-1:0] normal,
	output logic                                  degenerate,
	output logic [2:0][tfn_pkg::FIELD_W-1:0]      write_idx
);
	import tfn_pkg::*;

	logic [SHAMT_W-1:0] bl_ext, amt;
	logic               go_right;
	logic [2:0][NORM_BITS-1:0] m_sc;

	always_comb begin
		logic [SH_W-1:0] wide;
		bl_ext   = SHAMT_W'(in_data.bl);
		go_right = bl_ext > SHAMT_W'(NORM_BITS);
		amt      = go_right ? (bl_ext - SHAMT_W'(NORM_BITS)) : (SHAMT_W'(NORM_BITS) - bl_ext);
		for (int k = 0; k < 3; k++) begin
			wide    = SH_W'(in_data.mag[k]);
			wide    = go_right ? (wide >> amt) : (wide << amt);
			m_sc[k] = wide[NORM_BITS-1:0];
		end
	end

	logic                          valid_s1, valid_s2, valid_s3;
	side_t                         side_s1, side_s2, side_s3;
	logic [2:0][2*NORM_BITS-1:0]   sq_s2;
	logic [SQ_W-1:0]               sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.m     <= m_sc;
		side_s1.neg   <= in_data.neg;
		side_s1.degen <= in_data.degen;
		side_s1.idx   <= in_data.idx;
		for (int k = 0; k < 3; k++) sq_s2[k] <= side_s1.m[k] * side_s1.m[k];
		side_s2 <= side_s1;
		sum_s3  <= SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);
		side_s3 <= side_s2;
	end

	// Square root, one result bit per stage.
	logic              rt_valid_s [ROOT_W+1];
	logic [REM_W-1:0]  rt_rem_s   [ROOT_W+1];
	logic [ROOT_W-1:0] rt_root_s  [ROOT_W+1];
	logic [SQ_W-1:0]   rt_rest_s  [ROOT_W+1];
	side_t             rt_side_s  [ROOT_W+1];

	assign rt_valid_s[0] = valid_s3;
	assign rt_rem_s[0]   = '0;
	assign rt_root_s[0]  = '0;
	assign rt_rest_s[0]  = sum_s3;
	assign rt_side_s[0]  = side_s3;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_root
		logic [REM_W+1:0] r2, trial;
		logic             ge;
		always_comb begin
			r2    = {rt_rem_s[g], rt_rest_s[g][SQ_W-1:SQ_W-2]};
			trial = (REM_W + 2)'({rt_root_s[g], 2'b01});
			ge    = r2 >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_valid_s[g+1] <= 1'b0;
			else rt_valid_s[g+1] <= rt_valid_s[g];
		end
		always_ff @(posedge clk) begin
			rt_rem_s[g+1]  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
			rt_root_s[g+1] <= {rt_root_s[g][ROOT_W-2:0], ge};
			rt_rest_s[g+1] <= rt_rest_s[g] << 2;
			rt_side_s[g+1] <= rt_side_s[g];
		end
	end

	// Division set up: n = (m * 32768 + L) / (2 * L).
	logic                 dv_valid_s [Q_BITS+1];
	logic [D_W-1:0]       dv_div_s   [Q_BITS+1];
	logic [2:0][D_W-1:0]  dv_rem_s   [Q_BITS+1];
	logic [2:0][Q_BITS-1:0] dv_low_s [Q_BITS+1];
	logic [2:0][Q_BITS-1:0] dv_q_s   [Q_BITS+1];
	side_t                dv_side_s  [Q_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_valid_s[0] <= 1'b0;
		else dv_valid_s[0] <= rt_valid_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		logic [N_W-1:0] num;
		for (int k = 0; k < 3; k++) begin
			num = {1'b0, rt_side_s[ROOT_W].m[k], {Q_BITS{1'b0}}} + N_W'(rt_root_s[ROOT_W]);
			dv_rem_s[0][k] <= D_W'(num[N_W-1:Q_BITS]);
			dv_low_s[0][k] <= num[Q_BITS-1:0];
			dv_q_s[0][k]   <= '0;
		end
		dv_div_s[0]  <= {rt_root_s[ROOT_W], 1'b0};
		dv_side_s[0] <= rt_side_s[ROOT_W];
	end

	for (genvar g = 0; g < Q_BITS; g++) begin : g_div
		logic [2:0][D_W:0] r2;
		logic [2:0]        ge;
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				r2[k] = {dv_rem_s[g][k], dv_low_s[g][k][Q_BITS-1]};
				ge[k] = r2[k] >= {1'b0, dv_div_s[g]};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_valid_s[g+1] <= 1'b0;
			else dv_valid_s[g+1] <= dv_valid_s[g];
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				dv_rem_s[g+1][k] <= ge[k] ? D_W'(r2[k] - {1'b0, dv_div_s[g]}) : D_W'(r2[k]);
				dv_low_s[g+1][k] <= dv_low_s[g][k] << 1;
				dv_q_s[g+1][k]   <= {dv_q_s[g][k][Q_BITS-2:0], ge[k]};
			end
			dv_div_s[g+1]  <= dv_div_s[g];
			dv_side_s[g+1] <= dv_side_s[g];
		end
	end

	// Output register: clamp, apply sign, force zero on a degenerate triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv_valid_s[Q_BITS];
	end

	always_ff @(posedge clk) begin
		logic [OUT_W-1:0] n;
		for (int k = 0; k < 3; k++) begin
			n = OUT_W'(dv_q_s[Q_BITS][k]);
			if (n > OUT_W'(ONE_Q14)) n = OUT_W'(ONE_Q14);
			if (dv_side_s[Q_BITS].degen) normal[k] <= '0;
			else normal[k] <= dv_side_s[Q_BITS].neg[k] ? (~n + 1'b1) : n;
		end
		degenerate <= dv_side_s[Q_BITS].degen;
		write_idx  <= dv_side_s[Q_BITS].idx;
	end

endmodule

>>> rtl/triangle_face_normal.sv
// Top level of the triangle face normal block: front, queue and back part.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
`timescale 1ns / 1ps

// One triangle is taken per cycle: a beat is accepted when start is high
// and busy is low, and its result shows on done for one cycle only. The
// delay to done comes from the 25-stage square root and the 15-stage
// divider of the back part, after a five-stage front and a one-entry
// pass through the queue. The back part never stalls, so the queue
// holds at most one beat and busy stays low in normal use.
module triangle_face_normal (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] v0_x,
	input  logic [15:0] v0_y,
	input  logic [15:0] v0_z,
	input  logic [15:0] v1_x,
	input  logic [15:0] v1_y,
	input  logic [15:0] v1_z,
	input  logic [15:0] v2_x,
	input  logic [15:0] v2_y,
	input  logic [15:0] v2_z,
	input  logic [15:0] idx0,
	input  logic [15:0] idx1,
	input  logic [15:0] idx2,
	output logic        done,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic        degenerate,
	output logic [15:0] write_idx0,
	output logic [15:0] write_idx1,
	output logic [15:0] write_idx2
);
	import tfn_pkg::*;

	logic  push, pop, full;
	qent_t push_data, pop_data;
	logic signed [2:0][OUT_W-1:0] normal;
	logic [2:0][FIELD_W-1:0]      write_idx;

	assign busy = full;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.v0        ({v0_z, v0_y, v0_x}),
		.v1        ({v1_z, v1_y, v1_x}),
		.v2        ({v2_z, v2_y, v2_x}),
		.idx       ({idx2, idx1, idx0}),
		.push      (push),
		.push_data (push_data)
	);

	tfn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full)
	);

	tfn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pop),
		.in_data    (pop_data),
		.done       (done),
		.normal     (normal),
		.degenerate (degenerate),
		.write_idx  (write_idx)
	);

	assign normal_x   = normal[0];
	assign normal_y   = normal[1];
	assign normal_z   = normal[2];
	assign write_idx0 = write_idx[0];
	assign write_idx1 = write_idx[1];
	assign write_idx2 = write_idx[2];

endmodule

>>> rtl/tfn_checker.sv
// Port-level assertions for the triangle face normal block, bound to its top.
// Depends on tfn_pkg and triangle_face_normal_assert.svh.
`timescale 1ns / 1ps
`include "triangle_face_normal_assert.svh"

module tfn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic               degenerate,
	input logic [15:0]        idx0,
	input logic [15:0]        write_idx0
);
	import tfn_pkg::*;

	// Every accepted beat comes out after the fixed latency, and only then.
	`TFN_ASSERT_NXT(a_lat_fwd, start && !busy, ##(LATENCY-1) done, "accepted beat gave no result")
	`TFN_ASSERT_IMP(a_lat_back, done, $past(start && !busy, LATENCY) && write_idx0 == $past(idx0, LATENCY), "result without matching beat")
	`TFN_ASSERT_IMP(a_degen, done && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate normal not zero")
	`TFN_ASSERT_IMP(a_range, done, normal_x >= -16384 && normal_x <= 16384 && normal_y >= -16384 && normal_y <= 16384 && normal_z >= -16384 && normal_z <= 16384, "normal out of Q1.14 range")

endmodule

bind triangle_face_normal tfn_checker u_chk (.*);
